/* src/egw_pkg.sv */
// ----------------------------------------------------------------------------
// egw_pkg - Exp-Golomb bit writer shared definitions
// Item layouts, opcodes, word geometry and byte ordering used across the
// bit writer modules.
// ----------------------------------------------------------------------------
package egw_pkg;

	localparam int WORD_BITS  = 32;
	localparam int WORD_BYTES = WORD_BITS / 8;
	localparam int FIFO_DEPTH = 4;

	localparam logic [31:0] UE_MAX = 32'h7FFF_FFFE;

	typedef enum logic [1:0] {
		OP_FIXED  = 2'd0,
		OP_UE     = 2'd1,
		OP_FINISH = 2'd2
	} op_t;

	typedef struct packed {
		op_t         opcode;
		logic [31:0] value;
		logic [5:0]  width;
		logic        pad_with_ones;
	} in_item_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic [2:0]           byte_count;
		logic                 last;
	} out_item_t;

	// Words produced by one input item, oldest first.
	typedef struct packed {
		logic [1:0] count;
		out_item_t  word_a;
		out_item_t  word_b;
	} push_t;

	// Move the first stream byte (MSB side) into bits 7:0.
	function automatic logic [WORD_BITS-1:0] byte_swap(input logic [WORD_BITS-1:0] w);
		logic [WORD_BITS-1:0] r;
		r = '0;
		for (int i = 0; i < WORD_BYTES; i++) begin
			r[8*i +: 8] = w[8*(WORD_BYTES-1-i) +: 8];
		end
		return r;
	endfunction

endpackage

/* src/egw_stream_if.sv */
// ----------------------------------------------------------------------------
// egw_stream_if - valid/ready item channel
// Carries one payload item per handshake; accepted when valid and ready.
// ----------------------------------------------------------------------------
interface egw_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

/* src/egw_packer.sv */
// ----------------------------------------------------------------------------
// egw_packer - bit packing datapath
// Holds the pending partial word and turns one item into zero, one or two
// finished stream words.
// ----------------------------------------------------------------------------
module egw_packer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  egw_pkg::in_item_t item,
	output egw_pkg::push_t   push
);

	// pending bits kept left-aligned, zeros below the count
	logic [31:0]  pend_q;
	logic [4:0]   cnt_q;

	logic [31:0]  ue_clamped;
	logic [30:0]  code;
	logic [4:0]   code_len;
	logic [5:0]   ue_bits;
	logic [5:0]   fixed_bits;
	logic [5:0]   nbits;
	logic [63:0]  vbits;
	logic [63:0]  vmask;
	logic [63:0]  vl;
	logic [127:0] acc;
	logic [6:0]   total;
	logic [5:0]   c1;
	logic [2:0]   fin_bytes;
	logic [5:0]   fin_bits;
	logic [31:0]  mask_t;
	logic [31:0]  mask_c1;
	logic [31:0]  fin_word;
	logic [31:0]  pend_d;
	logic [4:0]   cnt_d;
	logic [1:0]   n_words;
	egw_pkg::push_t push_d;

	always_comb begin
		ue_clamped = (item.value > egw_pkg::UE_MAX) ? egw_pkg::UE_MAX : item.value;
		code       = ue_clamped[30:0] + 31'd1;
		code_len   = '0;
		for (int i = 0; i < 31; i++) begin
			if (code[i]) code_len = 5'(i + 1);
		end
		// zero prefix plus the code itself: 2*len-1 bits
		ue_bits    = {code_len, 1'b0} - 6'd1;
		fixed_bits = (item.width > 6'd32) ? 6'd32 : item.width;

		nbits = '0;
		vbits = '0;
		unique case (item.opcode)
			egw_pkg::OP_FIXED: begin
				nbits = fixed_bits;
				vbits = {32'b0, item.value};
			end
			egw_pkg::OP_UE: begin
				nbits = ue_bits;
				vbits = {33'b0, code};
			end
			default: begin
				nbits = '0;
				vbits = '0;
			end
		endcase

		vmask = (64'd1 << nbits) - 64'd1;
		vl    = (vbits & vmask) << (7'd64 - {1'b0, nbits});
		acc   = {pend_q, 96'b0} | ({vl, 64'b0} >> cnt_q);
		total = {2'b0, cnt_q} + {1'b0, nbits};

		// finish: stop bit, pad to byte boundary, left-aligned
		c1        = {1'b0, cnt_q} + 6'd1;
		fin_bytes = 3'((c1 + 6'd7) >> 3);
		fin_bits  = {fin_bytes, 3'b000};
		mask_t    = ~(32'hFFFF_FFFF >> fin_bits);
		mask_c1   = ~(32'hFFFF_FFFF >> c1);
		fin_word  = pend_q | (32'h8000_0000 >> cnt_q)
			| ({32{item.pad_with_ones}} & mask_t & ~mask_c1);

		if (total >= 7'd64) begin
			n_words = 2'd2;
			pend_d  = acc[63:32];
		end else if (total >= 7'd32) begin
			n_words = 2'd1;
			pend_d  = acc[95:64];
		end else begin
			n_words = 2'd0;
			pend_d  = acc[127:96];
		end
		cnt_d = total[4:0];

		push_d.count             = '0;
		push_d.word_a.word       = egw_pkg::byte_swap(acc[127:96]);
		push_d.word_a.byte_count = 3'(egw_pkg::WORD_BYTES);
		push_d.word_a.last       = 1'b0;
		push_d.word_b.word       = egw_pkg::byte_swap(acc[95:64]);
		push_d.word_b.byte_count = 3'(egw_pkg::WORD_BYTES);
		push_d.word_b.last       = 1'b0;

		unique case (item.opcode) inside
			egw_pkg::OP_FIXED, egw_pkg::OP_UE: begin
				push_d.count = n_words;
			end
			egw_pkg::OP_FINISH: begin
				push_d.count             = 2'd1;
				push_d.word_a.word       = egw_pkg::byte_swap(fin_word);
				push_d.word_a.byte_count = fin_bytes;
				push_d.word_a.last       = 1'b1;
				pend_d                   = '0;
				cnt_d                    = '0;
			end
			default: begin
				// drop unknown opcodes, keep state
				push_d.count = '0;
				pend_d       = pend_q;
				cnt_d        = cnt_q;
			end
		endcase

		push = push_d;
		if (!take) push.count = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
			cnt_q  <= '0;
		end else if (take) begin
			pend_q <= pend_d;
			cnt_q  <= cnt_d;
		end
	end

endmodule

/* src/egw_out_fifo.sv */
// ----------------------------------------------------------------------------
// egw_out_fifo - result word queue
// Takes up to two words per cycle from the packer and presents one word per
// cycle on the output channel while it holds words and the receiver is ready.
// ----------------------------------------------------------------------------
module egw_out_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  egw_pkg::push_t  push,
	output logic            room,
	egw_stream_if.source    res
);

	localparam int PTR_W = $clog2(egw_pkg::FIFO_DEPTH);

	egw_pkg::out_item_t mem_q [egw_pkg::FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [PTR_W:0]     cnt_q;
	logic               pop;

	assign res.valid   = (cnt_q != '0);
	assign res.payload = mem_q[rd_q];
	assign pop         = res.valid && res.ready;
	// leave space for the two words one item can produce
	assign room        = (cnt_q <= (PTR_W+1)'(egw_pkg::FIFO_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem_q[wr_q] <= push.word_a;
		if (push.count == 2'd2) mem_q[wr_q + PTR_W'(1)] <= push.word_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.count);
			if (pop) rd_q <= rd_q + PTR_W'(1);
			cnt_q <= cnt_q + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
		end
	end

endmodule

/* src/exp_golomb_bit_writer_unit.sv */
// ----------------------------------------------------------------------------
// exp_golomb_bit_writer_unit - Exp-Golomb / fixed-field bitstream writer
//
// cmd channel: one operation per item - a fixed field of up to 32 bits, a
// ue(v) code, or a finish that adds the stop bit, pads to a byte and flushes.
// res channel: 32-bit stream words, first stream byte in bits 7:0, with a
// valid byte count and a last flag on the word flushed by a finish.
// An accepted item is registered, packed once the result queue has room, and
// its words enter a four-entry result queue, from which the first word is
// offered on res as soon as it has been written.
// A new item is taken every cycle while the queue has room
// for two words, so the rate is one item per cycle whenever the receiver
// keeps up; the bound is the queue's single read port, one word per cycle,
// which ue codes that complete two words can exceed.
// A stalled receiver fills the queue and then holds cmd.ready low; nothing
// is dropped. Reset empties the queue and the pending partial word.
// ----------------------------------------------------------------------------
module exp_golomb_bit_writer_unit (
	input  logic         clk,
	input  logic         arst_n,
	egw_stream_if.sink   cmd,
	egw_stream_if.source res
);

	egw_pkg::in_item_t item_s1;
	logic              valid_s1;
	logic              room;
	logic              advance;
	egw_pkg::push_t    push;

	assign advance   = valid_s1 && room;
	assign cmd.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.valid && cmd.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) item_s1 <= cmd.payload;
	end

	egw_packer u_packer (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance),
		.item   (item_s1),
		.push   (push)
	);

	egw_out_fifo u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.res    (res)
	);

endmodule

/* tb/tb_exp_golomb_bit_writer_unit.sv */
// ----------------------------------------------------------------------------
// tb_exp_golomb_bit_writer_unit - self-checking bench for the bit writer
// Sends fixed fields, ue(v) codes and stream closes on the cmd channel and
// checks every word on the res channel against a bit-accurate packer kept
// here. Both sides idle at random, and the receiver holds off for long
// stretches so that the result queue fills and cmd backs up.
// ----------------------------------------------------------------------------
module tb_exp_golomb_bit_writer_unit;

	localparam logic [1:0]  OP_UNUSED    = 2'd3;
	localparam int          RANDOM_OPS   = 1800;
	localparam int          HOLD_CYCLES  = 300;
	localparam int          HOLD_AT_A    = 100;
	localparam int          HOLD_AT_B    = 600;
	localparam int          DRAIN_CYCLES = 32;
	localparam int          LIMIT_CYCLES = 400000;

	typedef enum int unsigned {PACE_FULL, PACE_LIGHT, PACE_HEAVY} pace_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	egw_stream_if #(.payload_t(egw_pkg::in_item_t))  cmd_if ();
	egw_stream_if #(.payload_t(egw_pkg::out_item_t)) res_if ();

	exp_golomb_bit_writer_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_if.sink),
		.res    (res_if.source)
	);

	always #2 clk = ~clk;

	egw_pkg::in_item_t  stim_items[$];
	egw_pkg::out_item_t expected_words[$];
	logic [31:0] pack_bits;
	int unsigned pack_count;

	int unsigned errors, words_seen, lasts_seen;
	int unsigned n_fixed, n_ue, n_close, n_ignored, n_double;
	int unsigned send_wait, ready_wait, items_sent;
	pace_t       send_pace, recv_pace;

	// ------------------------------------------------------------------
	// Stream packer
	// ------------------------------------------------------------------
	function automatic logic [63:0] ones_mask(int unsigned n);
		return (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
	endfunction

	// Stream order puts the first byte in bits 7:0.
	function automatic void queue_word(logic [31:0] w, int unsigned nbytes, bit fin);
		egw_pkg::out_item_t o;
		o.word       = {<<8{w}};
		o.byte_count = nbytes[2:0];
		o.last       = fin;
		expected_words.push_back(o);
	endfunction

	function automatic void append_bits(logic [63:0] v, int unsigned n);
		logic [63:0] full;
		int unsigned take;
		if (n == 0)
			return;
		v = v & ones_mask(n);
		if (pack_count + n < 32) begin
			full       = ({32'd0, pack_bits} << n) | v;
			pack_bits  = full[31:0];
			pack_count = pack_count + n;
		end else begin
			take = 32 - pack_count;
			full = ({32'd0, pack_bits} << take) | (v >> (n - take));
			queue_word(full[31:0], 4, 1'b0);
			pack_bits  = v[31:0] & 32'(ones_mask(n - take));
			pack_count = n - take;
		end
	endfunction

	function automatic void append_ue(logic [31:0] val);
		logic [31:0] code, t;
		int unsigned len;
		if (val > egw_pkg::UE_MAX)
			val = egw_pkg::UE_MAX;
		code = val + 32'd1;
		len  = 0;
		t    = code;
		while (t != 0) begin
			len++;
			t = t >> 1;
		end
		append_bits(64'd0, len - 1);
		append_bits({32'd0, code}, len);
	endfunction

	// Stop bit, byte padding, then flush the left-aligned partial word.
	function automatic void close_stream(bit pad_ones, int unsigned mark);
		int unsigned        pad;
		egw_pkg::out_item_t o;
		append_bits(64'd1, 1);
		if (pack_count % 8 != 0) begin
			pad = 8 - pack_count % 8;
			append_bits(pad_ones ? ones_mask(pad) : 64'd0, pad);
		end
		if (pack_count != 0) begin
			queue_word(pack_bits << (32 - pack_count), pack_count / 8, 1'b1);
		end else if (expected_words.size() > mark) begin
			// the stop bit or padding closed a full word: it is the final one
			o = expected_words.pop_back();
			o.last = 1'b1;
			expected_words.push_back(o);
		end
		pack_bits  = '0;
		pack_count = 0;
	endfunction

	function automatic void predict_words(egw_pkg::in_item_t it);
		int unsigned mark;
		mark = expected_words.size();
		case (it.opcode)
			egw_pkg::OP_FIXED: begin
				append_bits({32'd0, it.value}, (it.width > 32) ? 32 : it.width);
				n_fixed++;
			end
			egw_pkg::OP_UE: begin
				append_ue(it.value);
				n_ue++;
			end
			egw_pkg::OP_FINISH: begin
				close_stream(it.pad_with_ones, mark);
				n_close++;
			end
			default: n_ignored++;
		endcase
		if (expected_words.size() - mark == 2)
			n_double++;
	endfunction

	// ------------------------------------------------------------------
	// Helpers
	// ------------------------------------------------------------------
	function automatic int unsigned draw_wait(pace_t pace);
		case (pace)
			PACE_FULL:  return 0;
			PACE_LIGHT: return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11) : 0;
			default:    return $urandom_range(0, 11);
		endcase
	endfunction

	function automatic egw_pkg::in_item_t make_item(logic [1:0] op, logic [31:0] val,
			logic [5:0] w, bit pad_ones);
		egw_pkg::in_item_t it;
		it.opcode        = egw_pkg::op_t'(op);
		it.value         = val;
		it.width         = w;
		it.pad_with_ones = pad_ones;
		return it;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch at word %0d: %s got %h want %h", words_seen, what, got, want);
	endtask

	// ------------------------------------------------------------------
	// cmd driver: predict on accept, hold while stalled, idle between items
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_if.valid   <= 1'b0;
			cmd_if.payload <= '0;
			send_wait      <= 0;
		end else begin
			if (cmd_if.valid && cmd_if.ready)
				predict_words(cmd_if.payload);
			if (!(cmd_if.valid && !cmd_if.ready)) begin
				if (send_wait != 0) begin
					cmd_if.valid <= 1'b0;
					send_wait    <= send_wait - 1;
				end else if (stim_items.size() != 0) begin
					cmd_if.valid   <= 1'b1;
					cmd_if.payload <= stim_items.pop_front();
					items_sent++;
					if (items_sent % 64 == 0)
						send_pace = pace_t'($urandom_range(0, 2));
					send_wait <= draw_wait(send_pace);
				end else begin
					cmd_if.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// res monitor: check each word, then pace ready
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		egw_pkg::out_item_t want;
		int unsigned        g;
		bit                 took;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
			ready_wait   <= 0;
		end else begin
			took = 1'b0;
			if (res_if.valid && res_if.ready) begin
				took = 1'b1;
				words_seen++;
				if (expected_words.size() == 0) begin
					report_mismatch("unexpected word", res_if.payload.word, '0);
				end else begin
					want = expected_words.pop_front();
					if (res_if.payload.word !== want.word)
						report_mismatch("word", res_if.payload.word, want.word);
					if (res_if.payload.byte_count !== want.byte_count)
						report_mismatch("byte_count", 32'(res_if.payload.byte_count),
							32'(want.byte_count));
					if (res_if.payload.last !== want.last)
						report_mismatch("last", 32'(res_if.payload.last),
							32'(want.last));
				end
				if (res_if.payload.last === 1'b1)
					lasts_seen++;
				if (words_seen % 100 == 0)
					recv_pace = pace_t'($urandom_range(0, 2));
			end
			if (took && (words_seen == HOLD_AT_A || words_seen == HOLD_AT_B)) begin
				// long hold-off: let the result queue fill and back up cmd
				res_if.ready <= 1'b0;
				ready_wait   <= HOLD_CYCLES;
			end else if (took) begin
				g = draw_wait(recv_pace);
				res_if.ready <= (g == 0);
				ready_wait   <= g;
			end else if (ready_wait != 0) begin
				res_if.ready <= (ready_wait == 1);
				ready_wait   <= ready_wait - 1;
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus and end of run
	// ------------------------------------------------------------------
	initial begin
		egw_pkg::in_item_t it;
		int unsigned       pick, real_ops;
		cmd_if.valid   = 1'b0;
		cmd_if.payload = '0;
		res_if.ready   = 1'b0;
		pack_bits      = '0;
		pack_count     = 0;
		send_pace      = PACE_LIGHT;
		recv_pace      = PACE_LIGHT;

		// directed: field extremes, clamp, ignored op, closes on and off word edges
		stim_items.push_back(make_item(egw_pkg::OP_FIXED,  32'hFFFF_FFFF, 6'd0,  1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_FIXED,  32'hFFFF_FFFE, 6'd1,  1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_FIXED,  32'h0000_0001, 6'd1,  1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_UE,     32'd0,         6'd0,  1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_UE,     32'd1,         6'd0,  1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_FINISH, 32'd0,         6'd0,  1'b1));
		stim_items.push_back(make_item(egw_pkg::OP_FINISH, 32'hFFFF_FFFF, 6'd63, 1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_FIXED,  32'hFFFF_FFFF, 6'd32, 1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_FIXED,  32'hA5A5_A5A5, 6'd63, 1'b1));
		stim_items.push_back(make_item(egw_pkg::OP_FIXED,  32'h1234_5678, 6'd40, 1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_UE,     32'hFFFF_FFFF, 6'd0,  1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_UE,     egw_pkg::UE_MAX, 6'd0, 1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_UE,     32'h7FFF_FFFF, 6'd0,  1'b0));
		stim_items.push_back(make_item(OP_UNUSED,          32'hDEAD_BEEF, 6'd17, 1'b1));
		stim_items.push_back(make_item(egw_pkg::OP_FINISH, 32'd0,         6'd0,  1'b1));
		stim_items.push_back(make_item(egw_pkg::OP_FIXED,  32'h00AB_CDEF, 6'd24, 1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_FINISH, 32'd0,         6'd0,  1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_FIXED,  32'h7FFF_FFFF, 6'd31, 1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_FINISH, 32'd0,         6'd0,  1'b1));
		stim_items.push_back(make_item(egw_pkg::OP_FIXED,  32'd0,         6'd31, 1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_UE,     egw_pkg::UE_MAX, 6'd0, 1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_FIXED,  32'd3,         6'd2,  1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_FINISH, 32'd0,         6'd0,  1'b1));
		stim_items.push_back(make_item(egw_pkg::OP_FIXED,  32'd0,         6'd5,  1'b0));
		stim_items.push_back(make_item(egw_pkg::OP_FINISH, 32'd0,         6'd0,  1'b0));

		// random streams: mostly fields and codes, closed now and then
		real_ops = 0;
		while (real_ops < RANDOM_OPS) begin
			pick = $urandom_range(0, 99);
			it.value         = $urandom;
			it.width         = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(33, 63))
				: 6'($urandom_range(0, 32));
			it.pad_with_ones = 1'($urandom_range(0, 1));
			if (pick < 3) begin
				it.opcode = egw_pkg::op_t'(OP_UNUSED);
			end else if (pick < 48) begin
				it.opcode = egw_pkg::OP_FIXED;
			end else if (pick < 88) begin
				it.opcode = egw_pkg::OP_UE;
				case ($urandom_range(0, 5)) inside
					0, 1, 2: it.value = $urandom_range(0, 255);
					3:       it.value = $urandom & 32'(ones_mask($urandom_range(1, 31)));
					4:       it.value = $urandom_range(32'h7FFF_FFF0, 32'h8000_000F);
					default: ;
				endcase
			end else begin
				it.opcode = egw_pkg::OP_FINISH;
			end
			if (pick >= 3)
				real_ops++;
			stim_items.push_back(it);
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (stim_items.size() != 0 || cmd_if.valid)
			@(posedge clk);
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d fixed fields, %0d ue codes, %0d stream closes, %0d ignored ops",
			n_fixed, n_ue, n_close, n_ignored);
		$display("checked %0d words, %0d flagged last, %0d items that completed two words",
			words_seen, lasts_seen, n_double);
		if (errors == 0)
			$display("exp_golomb_bit_writer_unit test passed");
		else
			$display("exp_golomb_bit_writer_unit test failed");
		$finish;
	end

	initial begin
		#(LIMIT_CYCLES * 4);
		$display("timeout with %0d words still expected", expected_words.size());
		$display("exp_golomb_bit_writer_unit test failed");
		$finish;
	end

endmodule
